// ===== hdl/gss_pkg.sv =====
// gss_pkg: shared types and codes of the gear shift sequencer
`default_nettype none
package gss_pkg;

   localparam int unsigned MS_W = 16;
   localparam int unsigned CSR_INDEX_W = 3;

   typedef enum logic [1:0] {
      CMD_TICK = 2'd0,
      CMD_UP = 2'd1,
      CMD_DOWN = 2'd2,
      CMD_CLUTCH = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      SEQ_IDLE = 3'd0,
      SEQ_UP_CUT = 3'd1,
      SEQ_UP_NEUTRAL = 3'd2,
      SEQ_DOWN = 3'd3,
      SEQ_CLUTCH_ON = 3'd4,
      SEQ_CLUTCH_OFF = 3'd5
   } seq_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_CUT_LENGTH = 3'd0,
      REG_UP_VALVE_LENGTH = 3'd1,
      REG_DOWN_CLUTCH_LENGTH = 3'd2,
      REG_DOWN_AFTER_CLUTCH_LENGTH = 3'd3,
      REG_SHIFT_HOLD_LENGTH = 3'd4,
      REG_CLUTCH_HOLD_LENGTH = 3'd5
   } csr_index_type;

   typedef struct packed {
      cmd_type cmd;
      logic clutch_pin;
      logic neutral_pin;
   } req_type;

   typedef struct packed {
      logic ignition_cut;
      logic up_valve;
      logic down_valve;
      logic clutch_valve;
      logic busy_res;
      logic [2:0] active_sequence;
   } rsp_type;

   // phase end points in ms, all saturated
   typedef struct packed {
      logic [MS_W-1:0] up_end;
      logic [MS_W-1:0] cut_end;
      logic [MS_W-1:0] up_total;
      logic [MS_W-1:0] neutral_total;
      logic [MS_W-1:0] clutch_end;
      logic [MS_W-1:0] down_end;
      logic [MS_W-1:0] down_total;
      logic [MS_W-1:0] clutch_total;
   } phase_ends_type;

endpackage
`default_nettype wire

// ===== hdl/gss_timing.sv =====
// gss_timing: phase length registers and derived phase end points
`default_nettype none
module gss_timing (
   input wire logic clock,
   input wire logic reset,
   input wire logic csr_write,
   input wire logic [gss_pkg::CSR_INDEX_W-1:0] csr_index,
   input wire logic [gss_pkg::MS_W-1:0] csr_data,
   output gss_pkg::phase_ends_type ends
);
   import gss_pkg::*;

   logic [MS_W-1:0] cut_ff, up_ff, down_clutch_ff, down_after_ff, shift_hold_ff, clutch_hold_ff;
   phase_ends_type ends_ff, ends_in;
   logic [MS_W:0] down_sum;

   function automatic logic [MS_W-1:0] sat16(input logic [MS_W:0] v);
      return v[MS_W] ? {MS_W{1'b1}} : v[MS_W-1:0];
   endfunction

   function automatic logic [MS_W:0] diff0(input logic [MS_W:0] a, input logic [MS_W:0] b);
      return (a > b) ? a - b : '0;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         cut_ff <= 16'd100;
         up_ff <= 16'd80;
         down_clutch_ff <= 16'd60;
         down_after_ff <= 16'd40;
         shift_hold_ff <= 16'd200;
         clutch_hold_ff <= 16'd400;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_CUT_LENGTH: cut_ff <= csr_data;
            REG_UP_VALVE_LENGTH: up_ff <= csr_data;
            REG_DOWN_CLUTCH_LENGTH: down_clutch_ff <= csr_data;
            REG_DOWN_AFTER_CLUTCH_LENGTH: down_after_ff <= csr_data;
            REG_SHIFT_HOLD_LENGTH: shift_hold_ff <= csr_data;
            REG_CLUTCH_HOLD_LENGTH: clutch_hold_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      down_sum = {1'b0, down_clutch_ff} + {1'b0, down_after_ff};
      ends_in.up_end = up_ff;
      ends_in.cut_end = sat16({1'b0, up_ff} + diff0({1'b0, cut_ff}, {1'b0, up_ff}));
      ends_in.up_total = sat16({1'b0, ends_in.cut_end}
                               + diff0({1'b0, shift_hold_ff}, {1'b0, cut_ff}));
      ends_in.neutral_total = sat16({1'b0, up_ff}
                                    + diff0({1'b0, shift_hold_ff}, {1'b0, up_ff}));
      ends_in.clutch_end = down_clutch_ff;
      ends_in.down_end = sat16(down_sum);
      ends_in.down_total = sat16({1'b0, ends_in.down_end}
                                 + diff0({1'b0, shift_hold_ff}, down_sum));
      ends_in.clutch_total = clutch_hold_ff;
   end

   // the user must change lengths only while idle; the block does not enforce it. ends_ff registers ends_in
   always_ff @(posedge clock) begin
      ends_ff <= ends_in;
   end

   assign ends = ends_ff;

endmodule
`default_nettype wire

// ===== hdl/gear_shift_sequencer.sv =====
// gear_shift_sequencer: shift request latching, sequencing and output timing
// an accepted req reaches rsp through the input register and then the result register
// throughput: one item per cycle unless rsp is stalled; each item does a single compare pass on the ms counter
// a full result register stalls req only once the input register also holds an item
// reset: synchronous, clears pending requests, sequence, counter and outputs,
// and loads the default phase lengths; no clearing pass
`default_nettype none
module gear_shift_sequencer (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   output logic req_ready,
   input wire gss_pkg::req_type req_data,
   output logic rsp_valid,
   input wire logic rsp_ready,
   output gss_pkg::rsp_type rsp_data,
   input wire logic csr_valid,
   output logic csr_ready,
   input wire logic [gss_pkg::CSR_INDEX_W-1:0] csr_index,
   input wire logic [gss_pkg::MS_W-1:0] csr_data
);
   import gss_pkg::*;

   phase_ends_type ends;
   req_type in_ff;
   logic in_valid_ff;
   rsp_type rsp_ff, rsp_in;
   logic rsp_valid_ff;
   logic advance;

   logic [3:0] pend_ff, pend_in;
   seq_type seq_ff, seq_in;
   logic [MS_W-1:0] elapsed_ff, elapsed_in;
   logic [3:0] lvl_ff, lvl_in;

   logic do_eval;
   seq_type eval_seq;
   logic [MS_W-1:0] e;
   logic [3:0] lv;
   logic [MS_W-1:0] total;
   logic eval_known;

   assign csr_ready = 1'b1;

   gss_timing u_timing (
      .clock(clock),
      .reset(reset),
      .csr_write(csr_valid),
      .csr_index(csr_index),
      .csr_data(csr_data),
      .ends(ends)
   );

   assign advance = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_ff <= req_data;
      end
   end

   // request latching and sequence start / step
   always_comb begin
      pend_in = pend_ff;
      elapsed_in = elapsed_ff;
      do_eval = 1'b0;
      eval_seq = seq_ff;
      case (in_ff.cmd)
         CMD_UP: begin
            if (seq_ff != SEQ_UP_CUT && seq_ff != SEQ_UP_NEUTRAL) pend_in[0] = 1'b1;
         end
         CMD_DOWN: begin
            if (seq_ff != SEQ_DOWN) pend_in[1] = 1'b1;
         end
         CMD_CLUTCH: begin
            if (in_ff.clutch_pin) begin
               if (seq_ff != SEQ_CLUTCH_OFF) pend_in[3] = 1'b1;
            end else begin
               if (seq_ff != SEQ_CLUTCH_ON) pend_in[2] = 1'b1;
            end
         end
         default: begin
            if (seq_ff != SEQ_IDLE) begin
               elapsed_in = elapsed_ff + {{(MS_W-1){1'b0}}, (elapsed_ff != {MS_W{1'b1}})};
               do_eval = 1'b1;
            end else if (pend_ff != 4'd0) begin
               elapsed_in = '0;
               do_eval = 1'b1;
               if (pend_ff[0]) begin
                  pend_in[0] = 1'b0;
                  eval_seq = in_ff.neutral_pin ? SEQ_UP_CUT : SEQ_UP_NEUTRAL;
               end else if (pend_ff[1]) begin
                  pend_in[1] = 1'b0;
                  eval_seq = SEQ_DOWN;
               end else if (pend_ff[2]) begin
                  pend_in[2] = 1'b0;
                  eval_seq = SEQ_CLUTCH_ON;
               end else begin
                  pend_in[3] = 1'b0;
                  eval_seq = SEQ_CLUTCH_OFF;
               end
            end
         end
      endcase
   end

   // output levels at the new elapsed time: bit0 cut, bit1 up, bit2 down, bit3 clutch
   always_comb begin
      e = elapsed_in;
      lv = 4'd0;
      total = '0;
      eval_known = 1'b1;
      case (eval_seq)
         SEQ_UP_CUT: begin
            lv = {lvl_ff[3], 1'b0, (e < ends.up_end), (e < ends.cut_end)};
            total = ends.up_total;
         end
         SEQ_UP_NEUTRAL: begin
            lv = {lvl_ff[3], 1'b0, (e < ends.up_end), 1'b0};
            total = ends.neutral_total;
         end
         SEQ_DOWN: begin
            lv = {(e < ends.clutch_end), (e < ends.down_end), 2'b00};
            total = ends.down_total;
         end
         SEQ_CLUTCH_ON: begin
            lv = 4'b1000;
            total = ends.clutch_total;
         end
         SEQ_CLUTCH_OFF: begin
            lv = 4'b0000;
            total = ends.clutch_total;
         end
         default: begin
            eval_known = 1'b0;
         end
      endcase
   end

   always_comb begin
      lvl_in = lvl_ff;
      seq_in = seq_ff;
      if (do_eval) begin
         if (!eval_known) begin
            seq_in = SEQ_IDLE;
         end else begin
            lvl_in = lv;
            seq_in = (e >= total) ? SEQ_IDLE : eval_seq;
         end
      end
      rsp_in.ignition_cut = lvl_in[0];
      rsp_in.up_valve = lvl_in[1];
      rsp_in.down_valve = lvl_in[2];
      rsp_in.clutch_valve = lvl_in[3];
      rsp_in.busy_res = (seq_in != SEQ_IDLE);
      rsp_in.active_sequence = seq_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 4'd0;
         seq_ff <= SEQ_IDLE;
         elapsed_ff <= '0;
         lvl_ff <= 4'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (advance) begin
            pend_ff <= pend_in;
            seq_ff <= seq_in;
            elapsed_ff <= elapsed_in;
            lvl_ff <= lvl_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   a_down_not_pending: assert property (@(posedge clock) disable iff (reset)
      seq_ff == SEQ_DOWN |-> !pend_ff[1])
      else $error("downshift running while still pending");

   a_up_not_pending: assert property (@(posedge clock) disable iff (reset)
      (seq_ff == SEQ_UP_CUT || seq_ff == SEQ_UP_NEUTRAL) |-> !pend_ff[0])
      else $error("upshift running while still pending");

   a_advance_gives_result: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("processed item produced no result");

   a_stalled_item_held: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_ff))
      else $error("stalled input item lost or changed");

   a_busy_matches_sequence: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_ff.busy_res == (seq_ff != SEQ_IDLE))
      else $error("busy flag disagrees with running sequence");

endmodule
`default_nettype wire

// ===== bench/gear_shift_sequencer_tb.sv =====
// gear_shift_sequencer_tb: self-checking bench with an in-line shift timing predictor
`default_nettype none
module gear_shift_sequencer_tb;
   import gss_pkg::*;

   localparam int unsigned MS_MAX = (1 << MS_W) - 1;
   localparam int PEND_UP = 0;
   localparam int PEND_DOWN = 1;
   localparam int PEND_CLUTCH_ON = 2;
   localparam int PEND_CLUTCH_OFF = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_STRAY_FIRST = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_STRAY_LAST = 3'd7;
   localparam int STALL_LIMIT = 2000;
   localparam int LONG_HOLD = 60;
   localparam int SETTLE_CYCLES = 8;
   localparam int MODES = 3;
   localparam int LENGTH_SETS = 6;
   localparam int ITEMS_PER_SET = 100;

   class shift_checker;
      logic [MS_W-1:0] lengths [6];
      logic [3:0] pending_mask;
      seq_type running;
      logic [MS_W-1:0] elapsed;
      logic cut_on, up_on, down_on, clutch_on;
      rsp_type expected_levels [$];
      int errors;
      int items_seen;
      int outputs_checked;
      int started [6];

      function new();
         lengths[REG_CUT_LENGTH] = 16'd100;
         lengths[REG_UP_VALVE_LENGTH] = 16'd80;
         lengths[REG_DOWN_CLUTCH_LENGTH] = 16'd60;
         lengths[REG_DOWN_AFTER_CLUTCH_LENGTH] = 16'd40;
         lengths[REG_SHIFT_HOLD_LENGTH] = 16'd200;
         lengths[REG_CLUTCH_HOLD_LENGTH] = 16'd400;
         pending_mask = '0;
         running = SEQ_IDLE;
         elapsed = '0;
         {cut_on, up_on, down_on, clutch_on} = '0;
         errors = 0;
         items_seen = 0;
         outputs_checked = 0;
         foreach (started[i]) started[i] = 0;
      endfunction

      function int pending();
         return expected_levels.size();
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] idx, logic [MS_W-1:0] val);
         if (idx <= REG_CLUTCH_HOLD_LENGTH) lengths[idx] = val;
      endfunction

      function int unsigned clamp_ms(int unsigned v);
         return (v > MS_MAX) ? MS_MAX : v;
      endfunction

      function int unsigned gap_ms(int unsigned a, int unsigned b);
         return (a > b) ? a - b : 0;
      endfunction

      // output levels for the current elapsed time, idle once the total is reached
      function void time_outputs();
         int unsigned c, u, d, a, h, k;
         int unsigned cut_end, down_end, total;
         c = lengths[REG_CUT_LENGTH];
         u = lengths[REG_UP_VALVE_LENGTH];
         d = lengths[REG_DOWN_CLUTCH_LENGTH];
         a = lengths[REG_DOWN_AFTER_CLUTCH_LENGTH];
         h = lengths[REG_SHIFT_HOLD_LENGTH];
         k = lengths[REG_CLUTCH_HOLD_LENGTH];
         case (running)
            SEQ_UP_CUT: begin
               cut_end = clamp_ms(u + gap_ms(c, u));
               total = clamp_ms(cut_end + gap_ms(h, c));
               up_on = elapsed < u;
               cut_on = elapsed < cut_end;
               down_on = 1'b0;
            end
            SEQ_UP_NEUTRAL: begin
               total = clamp_ms(u + gap_ms(h, u));
               up_on = elapsed < u;
               cut_on = 1'b0;
               down_on = 1'b0;
            end
            SEQ_DOWN: begin
               down_end = clamp_ms(d + a);
               total = clamp_ms(down_end + gap_ms(h, d + a));
               clutch_on = elapsed < d;
               down_on = elapsed < down_end;
               cut_on = 1'b0;
               up_on = 1'b0;
            end
            SEQ_CLUTCH_ON: begin
               {cut_on, up_on, down_on, clutch_on} = 4'b0001;
               total = k;
            end
            SEQ_CLUTCH_OFF: begin
               {cut_on, up_on, down_on, clutch_on} = 4'b0000;
               total = k;
            end
            default: begin
               running = SEQ_IDLE;
               return;
            end
         endcase
         if (elapsed >= total) running = SEQ_IDLE;
      endfunction

      function void note_input(req_type item);
         rsp_type levels;
         items_seen++;
         case (item.cmd)
            CMD_UP: begin
               if (running != SEQ_UP_CUT && running != SEQ_UP_NEUTRAL)
                  pending_mask[PEND_UP] = 1'b1;
            end
            CMD_DOWN: begin
               if (running != SEQ_DOWN) pending_mask[PEND_DOWN] = 1'b1;
            end
            CMD_CLUTCH: begin
               if (item.clutch_pin) begin
                  if (running != SEQ_CLUTCH_OFF) pending_mask[PEND_CLUTCH_OFF] = 1'b1;
               end else if (running != SEQ_CLUTCH_ON) begin
                  pending_mask[PEND_CLUTCH_ON] = 1'b1;
               end
            end
            CMD_TICK: begin
               if (running != SEQ_IDLE) begin
                  if (elapsed != MS_MAX) elapsed++;
                  time_outputs();
               end else if (pending_mask != '0) begin
                  if (pending_mask[PEND_UP]) begin
                     pending_mask[PEND_UP] = 1'b0;
                     running = item.neutral_pin ? SEQ_UP_CUT : SEQ_UP_NEUTRAL;
                  end else if (pending_mask[PEND_DOWN]) begin
                     pending_mask[PEND_DOWN] = 1'b0;
                     running = SEQ_DOWN;
                  end else if (pending_mask[PEND_CLUTCH_ON]) begin
                     pending_mask[PEND_CLUTCH_ON] = 1'b0;
                     running = SEQ_CLUTCH_ON;
                  end else begin
                     pending_mask[PEND_CLUTCH_OFF] = 1'b0;
                     running = SEQ_CLUTCH_OFF;
                  end
                  started[running]++;
                  elapsed = '0;
                  time_outputs();
               end
            end
         endcase
         levels.ignition_cut = cut_on;
         levels.up_valve = up_on;
         levels.down_valve = down_on;
         levels.clutch_valve = clutch_on;
         levels.busy_res = running != SEQ_IDLE;
         levels.active_sequence = running;
         expected_levels.push_back(levels);
      endfunction

      function void compare_field(string name, logic [2:0] want, logic [2:0] got);
         if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         end
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (expected_levels.size() == 0) begin
            errors++;
            $display("%0t: unexpected output item, expected none, actual %h", $time, got);
            return;
         end
         want = expected_levels.pop_front();
         outputs_checked++;
         compare_field("ignition_cut", want.ignition_cut, got.ignition_cut);
         compare_field("up_valve", want.up_valve, got.up_valve);
         compare_field("down_valve", want.down_valve, got.down_valve);
         compare_field("clutch_valve", want.clutch_valve, got.clutch_valve);
         compare_field("busy_res", want.busy_res, got.busy_res);
         compare_field("active_sequence", want.active_sequence, got.active_sequence);
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   logic req_valid;
   logic req_ready;
   req_type req_data;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic csr_valid;
   logic csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [MS_W-1:0] csr_data;

   shift_checker sb = new();
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_request = 0;
   int hold_left = 0;
   int stalled_cycles = 0;

   gear_shift_sequencer uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (hold_request != 0) begin
         hold_left = LONG_HOLD;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) sb.check_result(rsp_data);
         if (req_valid && req_ready) sb.note_input(req_data);
         if (csr_valid && csr_ready) sb.write_reg(csr_index, csr_data);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         stalled_cycles = 0;
      end else begin
         stalled_cycles++;
         if (stalled_cycles >= STALL_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   task automatic send_item(input cmd_type cmd, input logic clutch_pin,
                            input logic neutral_pin);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_data <= '{cmd: cmd, clutch_pin: clutch_pin, neutral_pin: neutral_pin};
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic send_random_item();
      int r;
      cmd_type cmd;
      r = $urandom_range(99);
      cmd = (r < 55) ? CMD_TICK : (r < 70) ? CMD_UP : (r < 82) ? CMD_DOWN : CMD_CLUTCH;
      send_item(cmd, 1'($urandom_range(1)), 1'($urandom_range(1)));
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx, input logic [MS_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic load_lengths(input logic [MS_W-1:0] cut, up, down_clutch, down_after,
                               shift_hold, clutch_hold, input bit stray);
      write_csr(REG_CUT_LENGTH, cut);
      write_csr(REG_UP_VALVE_LENGTH, up);
      if (stray)
         write_csr(CSR_STRAY_FIRST + 3'($urandom_range(1)), 16'($urandom_range(MS_MAX)));
      write_csr(REG_DOWN_CLUTCH_LENGTH, down_clutch);
      write_csr(REG_DOWN_AFTER_CLUTCH_LENGTH, down_after);
      write_csr(REG_SHIFT_HOLD_LENGTH, shift_hold);
      write_csr(REG_CLUTCH_HOLD_LENGTH, clutch_hold);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [MS_W-1:0] random_length();
      int r;
      r = $urandom_range(99);
      if (r < 10) return '0;
      if (r < 85) return MS_W'($urandom_range(1, 12));
      if (r < 97) return MS_W'($urandom_range(13, 40));
      return MS_W'(MS_MAX);
   endfunction

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '{cmd: CMD_TICK, clutch_pin: 1'b0, neutral_pin: 1'b0};
      csr_valid = 1'b0;
      csr_index = REG_CUT_LENGTH;
      csr_data = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // reset lengths: requests latch, upshift wins priority, repeats merge
      send_item(CMD_TICK, 1'b0, 1'b1);
      send_item(CMD_UP, 1'b1, 1'b0);
      send_item(CMD_DOWN, 1'b0, 1'b0);
      send_item(CMD_CLUTCH, 1'b0, 1'b1);
      send_item(CMD_CLUTCH, 1'b1, 1'b0);
      send_item(CMD_TICK, 1'b0, 1'b1);
      send_item(CMD_UP, 1'b0, 1'b1);
      send_item(CMD_TICK, 1'b1, 1'b0);
      send_item(CMD_TICK, 1'b0, 1'b0);

      // zero lengths: each sequence starts and ends on one tick
      wait_drained();
      load_lengths('0, '0, '0, '0, '0, '0, 1'b1);
      send_item(CMD_TICK, 1'b0, 1'b0);
      send_item(CMD_TICK, 1'b0, 1'b0);
      send_item(CMD_TICK, 1'b1, 1'b1);
      send_item(CMD_TICK, 1'b0, 1'b1);
      send_item(CMD_UP, 1'b1, 1'b1);
      send_item(CMD_TICK, 1'b1, 1'b0);

      // full-scale lengths: phase end points saturate
      wait_drained();
      load_lengths('1, '1, '1, '1, '1, '1, 1'b0);
      send_item(CMD_DOWN, 1'b1, 1'b1);
      send_item(CMD_TICK, 1'b0, 1'b1);
      send_item(CMD_TICK, 1'b0, 1'b0);
      send_item(CMD_CLUTCH, 1'b1, 1'b1);
      send_item(CMD_UP, 1'b0, 1'b0);

      // inconsistent lengths, changed while the downshift runs
      wait_drained();
      load_lengths(16'd3, 16'd7, 16'd2, 16'd4, 16'd1, 16'd2, 1'b0);
      send_item(CMD_TICK, 1'b0, 1'b1);
      send_item(CMD_TICK, 1'b0, 1'b1);
      send_item(CMD_TICK, 1'b0, 1'b1);
      send_item(CMD_TICK, 1'b0, 1'b1);
      send_item(CMD_TICK, 1'b1, 1'b1);

      for (int mode = 0; mode < MODES; mode++) begin
         send_idle_pct = (mode == 0) ? 35 : (mode == 1) ? 74 : 0;
         recv_idle_pct = (mode == 0) ? 74 : (mode == 1) ? 35 : 0;
         for (int set = 0; set < LENGTH_SETS; set++) begin
            wait_drained();
            load_lengths(random_length(), random_length(), random_length(),
                         random_length(), random_length(), random_length(),
                         $urandom_range(3) == 0);
            if (mode == MODES - 1 && set == 0) hold_request = 1;
            for (int n = 0; n < ITEMS_PER_SET; n++) begin
               if (n == ITEMS_PER_SET / 2 && set % 2 == 1) wait_drained();
               send_random_item();
            end
         end
      end

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("covered %0d items: reset, zero, full-scale and %0d random length sets",
               sb.items_seen, MODES * LENGTH_SETS);
      $display("starts: up/cut %0d, up/neutral %0d, down %0d, clutch on %0d, off %0d",
               sb.started[SEQ_UP_CUT], sb.started[SEQ_UP_NEUTRAL], sb.started[SEQ_DOWN],
               sb.started[SEQ_CLUTCH_ON], sb.started[SEQ_CLUTCH_OFF]);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
`default_nettype wire

// ===== sim.f =====
hdl/gss_pkg.sv
hdl/gss_timing.sv
hdl/gear_shift_sequencer.sv
bench/gear_shift_sequencer_tb.sv
